/* design/aabbcc_pkg.sv */
// Shared types, codes and width helpers for the AABB/circle collision test core.
`default_nettype none

package aabbcc_pkg;

    // Scale factors are always 12 bits wide; only their fraction point moves.
    localparam int SCALE_WIDTH = 12;

    // Result item has one data bit, carried in one byte of tdata.
    localparam int OUT_DATA_WIDTH = 8;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } op_t;

    typedef enum logic {
        KIND_BOX    = 1'b0,
        KIND_CIRCLE = 1'b1
    } kind_t;

    // Reference kind in the upper bit, test kind in the lower bit.
    localparam logic [1:0] PAIR_BOX_BOX = 2'b00;

    typedef struct packed {
        logic       sep;
        logic [1:0] pair_kind;
    } pair_flags_t;

    // Width of doubled coordinates (2*corner + 2*size) as signed values.
    function automatic int lin_width(input int coord_width, input int size_width);
        int size_out;
        size_out = size_width + 4;
        lin_width = ((coord_width > size_out) ? coord_width : size_out) + 3;
    endfunction

endpackage

`default_nettype wire

/* design/aabbcc_scale.sv */
// Collider forming: corner = pos + shift, scaled and saturated size (two stages).
`default_nettype none

module aabbcc_scale #(
    parameter int COORD_WIDTH     = 24,
    parameter int SIZE_WIDTH      = 16,
    parameter int SCALE_FRAC_BITS = 8
) (
    input  wire                                           clk,
    input  wire  [1:0]                                    stage_en,
    input  wire  aabbcc_pkg::kind_t                       kind_in,
    input  wire  signed [COORD_WIDTH-1:0]                 pos_x,
    input  wire  signed [COORD_WIDTH-1:0]                 pos_y,
    input  wire  signed [COORD_WIDTH-1:0]                 shift_x,
    input  wire  signed [COORD_WIDTH-1:0]                 shift_y,
    input  wire  [SIZE_WIDTH-1:0]                         box_w,
    input  wire  [SIZE_WIDTH-1:0]                         box_h,
    input  wire  [aabbcc_pkg::SCALE_WIDTH-1:0]            scale_x,
    input  wire  [aabbcc_pkg::SCALE_WIDTH-1:0]            scale_y,
    output aabbcc_pkg::kind_t                             kind_out,
    output logic signed [COORD_WIDTH:0]                   corner_x,
    output logic signed [COORD_WIDTH:0]                   corner_y,
    output logic [SIZE_WIDTH+3:0]                         size_w,
    output logic [SIZE_WIDTH+3:0]                         size_h
);

    localparam int SO = SIZE_WIDTH + 4;
    localparam int PW = SIZE_WIDTH + aabbcc_pkg::SCALE_WIDTH;

    // Truncate the product to the size fraction, clip at the size range.
    function automatic logic [SO-1:0] sat_size(input logic [PW-1:0] prod);
        logic [PW-1:0] shifted;
        shifted  = prod >> SCALE_FRAC_BITS;
        sat_size = (|shifted[PW-1:SO]) ? {SO{1'b1}} : shifted[SO-1:0];
    endfunction

    aabbcc_pkg::kind_t          kind_s1_reg;
    logic signed [COORD_WIDTH:0] cx_s1_reg, cy_s1_reg;
    logic [PW-1:0]               pw_s1_reg, ph_s1_reg;
    logic signed [COORD_WIDTH:0] cx_next, cy_next;
    logic [PW-1:0]               pw_next, ph_next;

    aabbcc_pkg::kind_t          kind_s2_reg;
    logic signed [COORD_WIDTH:0] cx_s2_reg, cy_s2_reg;
    logic [SO-1:0]               w_s2_reg, h_s2_reg;
    logic [SO-1:0]               w_next, h_next;

    always_comb
    begin
        cx_next = {pos_x[COORD_WIDTH-1], pos_x} + {shift_x[COORD_WIDTH-1], shift_x};
        cy_next = {pos_y[COORD_WIDTH-1], pos_y} + {shift_y[COORD_WIDTH-1], shift_y};
        pw_next = PW'(box_w) * PW'(scale_x);
        ph_next = PW'(box_h) * PW'(scale_y);
        w_next  = sat_size(pw_s1_reg);
        h_next  = sat_size(ph_s1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            kind_s1_reg <= kind_in;
            cx_s1_reg   <= cx_next;
            cy_s1_reg   <= cy_next;
            pw_s1_reg   <= pw_next;
            ph_s1_reg   <= ph_next;
        end
        if (stage_en[1])
        begin
            kind_s2_reg <= kind_s1_reg;
            cx_s2_reg   <= cx_s1_reg;
            cy_s2_reg   <= cy_s1_reg;
            w_s2_reg    <= w_next;
            h_s2_reg    <= h_next;
        end
    end

    assign kind_out = kind_s2_reg;
    assign corner_x = cx_s2_reg;
    assign corner_y = cy_s2_reg;
    assign size_w   = w_s2_reg;
    assign size_h   = h_s2_reg;

endmodule

`default_nettype wire

/* design/aabbcc_setup.sv */
// Reference store, AABB separation test and clamp operand selection (two stages).
`default_nettype none

module aabbcc_setup #(
    parameter int COORD_WIDTH = 24,
    parameter int SIZE_WIDTH  = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire  [1:0]                         stage_en,
    input  wire                                load_ref,
    input  wire  aabbcc_pkg::kind_t            kind_in,
    input  wire  signed [COORD_WIDTH:0]        corner_x,
    input  wire  signed [COORD_WIDTH:0]        corner_y,
    input  wire  [SIZE_WIDTH+3:0]              size_w,
    input  wire  [SIZE_WIDTH+3:0]              size_h,
    output aabbcc_pkg::pair_flags_t            flags,
    output logic signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] lo_x,
    output logic signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] hi_x,
    output logic signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] mid_x,
    output logic signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] lo_y,
    output logic signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] hi_y,
    output logic signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] mid_y,
    output logic [SIZE_WIDTH+4:0]              radius
);

    localparam int SO = SIZE_WIDTH + 4;
    localparam int CW = COORD_WIDTH;
    localparam int LW = aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH);

    // Reference collider, cleared to a zero-size box at the origin.
    aabbcc_pkg::kind_t   ref_kind_reg;
    logic signed [CW:0]  ref_cx_reg, ref_cy_reg;
    logic [SO-1:0]       ref_w_reg, ref_h_reg;

    // Stage 3: reference (a) and test collider (b) side by side.
    aabbcc_pkg::kind_t   a_kind_reg, b_kind_reg;
    logic signed [CW:0]  a_x_reg, a_y_reg, b_x_reg, b_y_reg;
    logic [SO-1:0]       a_w_reg, a_h_reg, b_w_reg, b_h_reg;

    // Stage 4 outputs.
    aabbcc_pkg::pair_flags_t flags_reg, flags_next;
    logic signed [LW-1:0]    lo_x_reg, hi_x_reg, mid_x_reg, lo_y_reg, hi_y_reg, mid_y_reg;
    logic signed [LW-1:0]    lo_x_next, hi_x_next, mid_x_next;
    logic signed [LW-1:0]    lo_y_next, hi_y_next, mid_y_next;
    logic [SO:0]             radius_reg, radius_next;

    logic signed [LW-1:0] ax_e, ay_e, aw_e, ah_e, bx_e, by_e, bw_e, bh_e;
    logic signed [LW-1:0] ax2, ay2, axe2, aye2, axm, aym;
    logic signed [LW-1:0] bx2, by2, bxe2, bye2, bxm, bym;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_kind_reg <= aabbcc_pkg::KIND_BOX;
            ref_cx_reg   <= '0;
            ref_cy_reg   <= '0;
            ref_w_reg    <= '0;
            ref_h_reg    <= '0;
        end
        else if (load_ref)
        begin
            ref_kind_reg <= kind_in;
            ref_cx_reg   <= corner_x;
            ref_cy_reg   <= corner_y;
            ref_w_reg    <= size_w;
            ref_h_reg    <= size_h;
        end
    end

    always_comb
    begin
        ax_e = {{(LW-CW-1){a_x_reg[CW]}}, a_x_reg};
        ay_e = {{(LW-CW-1){a_y_reg[CW]}}, a_y_reg};
        bx_e = {{(LW-CW-1){b_x_reg[CW]}}, b_x_reg};
        by_e = {{(LW-CW-1){b_y_reg[CW]}}, b_y_reg};
        aw_e = {{(LW-SO){1'b0}}, a_w_reg};
        ah_e = {{(LW-SO){1'b0}}, a_h_reg};
        bw_e = {{(LW-SO){1'b0}}, b_w_reg};
        bh_e = {{(LW-SO){1'b0}}, b_h_reg};

        // Doubled edges and centres keep the circle math in integers.
        ax2  = {ax_e[LW-2:0], 1'b0};
        ay2  = {ay_e[LW-2:0], 1'b0};
        bx2  = {bx_e[LW-2:0], 1'b0};
        by2  = {by_e[LW-2:0], 1'b0};
        axe2 = ax2 + {aw_e[LW-2:0], 1'b0};
        aye2 = ay2 + {ah_e[LW-2:0], 1'b0};
        bxe2 = bx2 + {bw_e[LW-2:0], 1'b0};
        bye2 = by2 + {bh_e[LW-2:0], 1'b0};
        axm  = ax2 + aw_e;
        aym  = ay2 + ah_e;
        bxm  = bx2 + bw_e;
        bym  = by2 + bh_e;

        flags_next.pair_kind = {a_kind_reg, b_kind_reg};
        flags_next.sep = (ax_e + aw_e <= bx_e) || (ax_e >= bx_e + bw_e)
                      || (ay_e + ah_e <= by_e) || (ay_e >= by_e + bh_e);

        if (a_kind_reg == aabbcc_pkg::KIND_CIRCLE && b_kind_reg == aabbcc_pkg::KIND_CIRCLE)
        begin
            // Two circles: a degenerate clamp range at the reference centre
            // turns the gap into the centre distance.
            lo_x_next   = axm;
            hi_x_next   = axm;
            mid_x_next  = bxm;
            lo_y_next   = aym;
            hi_y_next   = aym;
            mid_y_next  = bym;
            radius_next = {1'b0, a_w_reg} + {1'b0, b_w_reg};
        end
        else if (a_kind_reg == aabbcc_pkg::KIND_BOX)
        begin
            // Reference is the box; also covers box against box (result unused).
            lo_x_next   = ax2;
            hi_x_next   = axe2;
            mid_x_next  = bxm;
            lo_y_next   = ay2;
            hi_y_next   = aye2;
            mid_y_next  = bym;
            radius_next = {1'b0, b_w_reg};
        end
        else
        begin
            lo_x_next   = bx2;
            hi_x_next   = bxe2;
            mid_x_next  = axm;
            lo_y_next   = by2;
            hi_y_next   = bye2;
            mid_y_next  = aym;
            radius_next = {1'b0, a_w_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            a_kind_reg <= ref_kind_reg;
            a_x_reg    <= ref_cx_reg;
            a_y_reg    <= ref_cy_reg;
            a_w_reg    <= ref_w_reg;
            a_h_reg    <= ref_h_reg;
            b_kind_reg <= kind_in;
            b_x_reg    <= corner_x;
            b_y_reg    <= corner_y;
            b_w_reg    <= size_w;
            b_h_reg    <= size_h;
        end
        if (stage_en[1])
        begin
            flags_reg  <= flags_next;
            lo_x_reg   <= lo_x_next;
            hi_x_reg   <= hi_x_next;
            mid_x_reg  <= mid_x_next;
            lo_y_reg   <= lo_y_next;
            hi_y_reg   <= hi_y_next;
            mid_y_reg  <= mid_y_next;
            radius_reg <= radius_next;
        end
    end

    assign flags  = flags_reg;
    assign lo_x   = lo_x_reg;
    assign hi_x   = hi_x_reg;
    assign mid_x  = mid_x_reg;
    assign lo_y   = lo_y_reg;
    assign hi_y   = hi_y_reg;
    assign mid_y  = mid_y_reg;
    assign radius = radius_reg;

endmodule

`default_nettype wire

/* design/aabbcc_dist.sv */
// Clamped gap per axis and squared distances (two stages).
`default_nettype none

module aabbcc_dist #(
    parameter int COORD_WIDTH = 24,
    parameter int SIZE_WIDTH  = 16
) (
    input  wire                                clk,
    input  wire  [1:0]                         stage_en,
    input  wire  aabbcc_pkg::pair_flags_t      flags_in,
    input  wire  signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] lo_x,
    input  wire  signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] hi_x,
    input  wire  signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] mid_x,
    input  wire  signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] lo_y,
    input  wire  signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] hi_y,
    input  wire  signed [aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] mid_y,
    input  wire  [SIZE_WIDTH+4:0]              radius,
    output aabbcc_pkg::pair_flags_t            flags,
    output logic [2*aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] sq_x,
    output logic [2*aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH)-1:0] sq_y,
    output logic [2*SIZE_WIDTH+9:0]            sq_r
);

    localparam int LW = aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH);
    localparam int RW = SIZE_WIDTH + 5;

    // Distance from mid to the range [lo, hi]; lo <= hi always holds.
    function automatic logic [LW-1:0] gap(input logic signed [LW-1:0] lo,
                                          input logic signed [LW-1:0] hi,
                                          input logic signed [LW-1:0] mid);
        logic signed [LW:0] below;
        logic signed [LW:0] above;
        below = {lo[LW-1], lo} - {mid[LW-1], mid};
        above = {mid[LW-1], mid} - {hi[LW-1], hi};
        if (!below[LW])
            gap = below[LW-1:0];
        else if (!above[LW])
            gap = above[LW-1:0];
        else
            gap = '0;
    endfunction

    aabbcc_pkg::pair_flags_t flags_s5_reg, flags_s6_reg;
    logic [LW-1:0]           mag_x_reg, mag_y_reg, mag_x_next, mag_y_next;
    logic [RW-1:0]           rad_reg;
    logic [2*LW-1:0]         sq_x_reg, sq_y_reg, sq_x_next, sq_y_next;
    logic [2*RW-1:0]         sq_r_reg, sq_r_next;

    always_comb
    begin
        mag_x_next = gap(lo_x, hi_x, mid_x);
        mag_y_next = gap(lo_y, hi_y, mid_y);
        sq_x_next  = mag_x_reg * mag_x_reg;
        sq_y_next  = mag_y_reg * mag_y_reg;
        sq_r_next  = rad_reg * rad_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            flags_s5_reg <= flags_in;
            mag_x_reg    <= mag_x_next;
            mag_y_reg    <= mag_y_next;
            rad_reg      <= radius;
        end
        if (stage_en[1])
        begin
            flags_s6_reg <= flags_s5_reg;
            sq_x_reg     <= sq_x_next;
            sq_y_reg     <= sq_y_next;
            sq_r_reg     <= sq_r_next;
        end
    end

    assign flags = flags_s6_reg;
    assign sq_x  = sq_x_reg;
    assign sq_y  = sq_y_reg;
    assign sq_r  = sq_r_reg;

endmodule

`default_nettype wire

/* design/aabb_circle_collision_test_core.sv */
// Top level of the AABB/circle collision test core: handshake, pipeline control, decision.
//
// Usage:
//   Slave channel (s_*): one transaction per collider. s_tuser[0] is the op
//   (load the reference collider, or test against it), s_tuser[1] the shape
//   (box, or circle inscribed in the box width). s_tdata carries position,
//   offset, unscaled size and scale factors.
//   Master channel (m_*): one transaction per test item, m_tdata[0] = hit,
//   m_tuser = reference kind * 2 + test kind. Load items give no transaction.
//   Throughput: one item per clock; every stage has its own valid bit and
//   only stops when the stage after it is full, so bubbles close up.
//   Pipeline: six register stages plus the output register.
//   Stages: corner add and scale multiply, size saturation, reference
//   capture, separation test and clamp setup, clamp, squaring; the sum and
//   compare of the squared distances feed the output register.
//   A test item sees every load accepted before it, even one taken in the
//   previous cycle: the reference is written as the load leaves stage two.
//   Reset: all stages empty, no output pending, reference is a zero-size
//   box at the origin.
//   Receiver stall: the output register holds its transaction while
//   m_tready is low; stages behind it keep filling until the pipe is full,
//   then s_tready drops. Nothing is dropped or repeated.
`default_nettype none

module aabb_circle_collision_test_core #(
    parameter int COORD_WIDTH     = 24,
    parameter int SIZE_WIDTH      = 16,
    parameter int SCALE_FRAC_BITS = 8
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // pos_x, pos_y, shift_x, shift_y, box_w, box_h, scale_x, scale_y, zero fill
    input  wire  [((4*COORD_WIDTH + 2*SIZE_WIDTH + 2*aabbcc_pkg::SCALE_WIDTH + 7) / 8) * 8 - 1:0]
                                         s_tdata,
    // op, shape_kind
    input  wire  [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // hit, zero fill
    output logic [aabbcc_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
    // pair_kind
    output logic [1:0]                   m_tuser
);

    localparam int CW  = COORD_WIDTH;
    localparam int SW  = SIZE_WIDTH;
    localparam int KW  = aabbcc_pkg::SCALE_WIDTH;
    localparam int SO  = SW + 4;
    localparam int LW  = aabbcc_pkg::lin_width(COORD_WIDTH, SIZE_WIDTH);
    localparam int RW  = SO + 1;
    localparam int SUMW = 2*LW + 1;
    localparam int ODW = aabbcc_pkg::OUT_DATA_WIDTH;

    // Field offsets in s_tdata, lowest first.
    localparam int POS_X_LSB   = 0;
    localparam int POS_Y_LSB   = POS_X_LSB + CW;
    localparam int SHIFT_X_LSB = POS_Y_LSB + CW;
    localparam int SHIFT_Y_LSB = SHIFT_X_LSB + CW;
    localparam int BOX_W_LSB   = SHIFT_Y_LSB + CW;
    localparam int BOX_H_LSB   = BOX_W_LSB + SW;
    localparam int SCALE_X_LSB = BOX_H_LSB + SW;
    localparam int SCALE_Y_LSB = SCALE_X_LSB + KW;

    // Pipeline control: stage k valid/op, stage 7 is the output register.
    logic [6:1]          vld_reg, vld_next;
    aabbcc_pkg::op_t     op_reg [1:6];
    logic [7:1]          stage_rdy;
    logic                load_ref;

    logic                out_vld_reg, out_vld_next;
    logic                hit_reg, hit_next;
    logic [1:0]          pair_reg;

    // Datapath between modules.
    aabbcc_pkg::kind_t       kind_s2;
    logic signed [CW:0]      corner_x_s2, corner_y_s2;
    logic [SO-1:0]           size_w_s2, size_h_s2;
    aabbcc_pkg::pair_flags_t flags_s4, flags_s6;
    logic signed [LW-1:0]    lo_x_s4, hi_x_s4, mid_x_s4, lo_y_s4, hi_y_s4, mid_y_s4;
    logic [RW-1:0]           radius_s4;
    logic [2*LW-1:0]         sq_x_s6, sq_y_s6;
    logic [2*RW-1:0]         sq_r_s6;
    logic [SUMW-1:0]         dist_sum;
    logic                    in_circle;

    // Ready ripples back from the output register; a stage loads when it is
    // empty or its occupant moves on.
    always_comb
    begin
        stage_rdy[7] = !out_vld_reg || m_tready;
        for (int k = 6; k >= 1; k--)
            stage_rdy[k] = !vld_reg[k] || stage_rdy[k+1];
    end

    assign s_tready = stage_rdy[1];

    always_comb
    begin
        vld_next[1] = stage_rdy[1] ? s_tvalid : vld_reg[1];
        for (int k = 2; k <= 6; k++)
            vld_next[k] = stage_rdy[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Op travels beside the valid bits; only the valid bits need reset.
    always_ff @(posedge clk)
    begin
        if (stage_rdy[1])
            op_reg[1] <= aabbcc_pkg::op_t'(s_tuser[0]);
        for (int k = 2; k <= 6; k++)
            if (stage_rdy[k])
                op_reg[k] <= op_reg[k-1];
    end

    // Commit the reference as a load item leaves stage two.
    assign load_ref = stage_rdy[3] && vld_reg[2] && (op_reg[2] == aabbcc_pkg::OP_LOAD);

    aabbcc_scale #(
        .COORD_WIDTH     (COORD_WIDTH),
        .SIZE_WIDTH      (SIZE_WIDTH),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_scale (
        .clk      (clk),
        .stage_en (stage_rdy[2:1]),
        .kind_in  (aabbcc_pkg::kind_t'(s_tuser[1])),
        .pos_x    (s_tdata[POS_X_LSB +: CW]),
        .pos_y    (s_tdata[POS_Y_LSB +: CW]),
        .shift_x  (s_tdata[SHIFT_X_LSB +: CW]),
        .shift_y  (s_tdata[SHIFT_Y_LSB +: CW]),
        .box_w    (s_tdata[BOX_W_LSB +: SW]),
        .box_h    (s_tdata[BOX_H_LSB +: SW]),
        .scale_x  (s_tdata[SCALE_X_LSB +: KW]),
        .scale_y  (s_tdata[SCALE_Y_LSB +: KW]),
        .kind_out (kind_s2),
        .corner_x (corner_x_s2),
        .corner_y (corner_y_s2),
        .size_w   (size_w_s2),
        .size_h   (size_h_s2)
    );

    aabbcc_setup #(
        .COORD_WIDTH (COORD_WIDTH),
        .SIZE_WIDTH  (SIZE_WIDTH)
    ) u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_en (stage_rdy[4:3]),
        .load_ref (load_ref),
        .kind_in  (kind_s2),
        .corner_x (corner_x_s2),
        .corner_y (corner_y_s2),
        .size_w   (size_w_s2),
        .size_h   (size_h_s2),
        .flags    (flags_s4),
        .lo_x     (lo_x_s4),
        .hi_x     (hi_x_s4),
        .mid_x    (mid_x_s4),
        .lo_y     (lo_y_s4),
        .hi_y     (hi_y_s4),
        .mid_y    (mid_y_s4),
        .radius   (radius_s4)
    );

    aabbcc_dist #(
        .COORD_WIDTH (COORD_WIDTH),
        .SIZE_WIDTH  (SIZE_WIDTH)
    ) u_dist (
        .clk      (clk),
        .stage_en (stage_rdy[6:5]),
        .flags_in (flags_s4),
        .lo_x     (lo_x_s4),
        .hi_x     (hi_x_s4),
        .mid_x    (mid_x_s4),
        .lo_y     (lo_y_s4),
        .hi_y     (hi_y_s4),
        .mid_y    (mid_y_s4),
        .radius   (radius_s4),
        .flags    (flags_s6),
        .sq_x     (sq_x_s6),
        .sq_y     (sq_y_s6),
        .sq_r     (sq_r_s6)
    );

    // Final decision: separated boxes never hit, two boxes always hit once
    // they overlap, anything with a circle needs the squared gap strictly
    // below the squared (doubled) radius.
    always_comb
    begin
        dist_sum  = {1'b0, sq_x_s6} + {1'b0, sq_y_s6};
        in_circle = dist_sum < {{(SUMW-2*RW){1'b0}}, sq_r_s6};
        hit_next  = !flags_s6.sep
                 && ((flags_s6.pair_kind == aabbcc_pkg::PAIR_BOX_BOX) || in_circle);
        // Drop load items here; they have done their work at stage two.
        out_vld_next = stage_rdy[7] ? (vld_reg[6] && (op_reg[6] == aabbcc_pkg::OP_TEST))
                                    : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[7])
        begin
            hit_reg  <= hit_next;
            pair_reg <= flags_s6.pair_kind;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(ODW-1){1'b0}}, hit_reg};
    assign m_tuser  = pair_reg;

    // Input only stalls when every stage and the output register are full.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&vld_reg && out_vld_reg))
        else $error("input stalled with room in the pipeline");

    // An item in the last stage is held, not lost, while the output is blocked.
    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[6] && !stage_rdy[7]) |=> (vld_reg[6] && $stable(op_reg[6])))
        else $error("last stage item lost during output stall");

    // A test item leaving the last stage always shows up at the output.
    a_test_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_rdy[7] && vld_reg[6] && (op_reg[6] == aabbcc_pkg::OP_TEST)) |=> m_tvalid)
        else $error("test item did not reach the output");

    // Separated bounding boxes must never report a hit.
    a_sep_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_rdy[7] && vld_reg[6] && flags_s6.sep) |=> !hit_reg)
        else $error("hit reported for separated boxes");

endmodule

`default_nettype wire

/* tb/aabb_circle_collision_test_core_tb.sv */
// Self-checking testbench for the AABB/circle collision test core.
`default_nettype none

module aabb_circle_collision_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aabbcc_pkg::*;

    localparam int COORD_W   = 24;
    localparam int SIZE_W    = 16;
    localparam int FRAC_BITS = 8;
    localparam int TDATA_W   = ((4*COORD_W + 2*SIZE_W + 2*SCALE_WIDTH + 7) / 8) * 8;

    // Scaled sizes clamp to SIZE_W+4 bits.
    localparam longint SIZE_SAT   = (64'sd1 <<< (SIZE_W + 4)) - 1;
    localparam longint COORD_MAX  = 64'sd8388607;
    localparam longint COORD_MIN  = -64'sd8388608;
    // Corner = pos + shift, so it spans one bit more than either.
    localparam longint CORNER_MAX = 2 * COORD_MAX;
    localparam longint CORNER_MIN = 2 * COORD_MIN;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 300;

    typedef struct {
        op_t                        op;
        kind_t                      kind;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  shift_x;
        logic signed [COORD_W-1:0]  shift_y;
        logic [SIZE_W-1:0]          box_w;
        logic [SIZE_W-1:0]          box_h;
        logic [SCALE_WIDTH-1:0]     scale_x;
        logic [SCALE_WIDTH-1:0]     scale_y;
    } collider_t;

    typedef struct {
        logic       hit;
        logic [1:0] pair_kind;
    } verdict_t;

    // Holds the stored reference collider and the verdicts still owed by the block.
    class collision_predictor;
        kind_t    ref_kind;
        longint   ref_x, ref_y, ref_w, ref_h;
        verdict_t pending_verdicts[$];
        int       errors, loads, tests, hits;
        bit [3:0] pairs_seen;

        function new();
            ref_kind   = KIND_BOX;
            ref_x      = 0;
            ref_y      = 0;
            ref_w      = 0;
            ref_h      = 0;
            errors     = 0;
            loads      = 0;
            tests      = 0;
            hits       = 0;
            pairs_seen = '0;
        endfunction

        // size * scale, truncated and clamped
        function longint scaled(logic [SIZE_W-1:0] size, logic [SCALE_WIDTH-1:0] k);
            longint p;
            p = (longint'(size) * longint'(k)) >>> FRAC_BITS;
            return (p > SIZE_SAT) ? SIZE_SAT : p;
        endfunction

        // Box point nearest the circle centre must lie strictly inside it.
        // Works on doubled coordinates so the centre stays integral.
        function bit box_reaches_circle(longint bx, longint by, longint bw, longint bh,
                                        longint cx, longint cy, longint cw, longint ch);
            longint mx, my, nx, ny;
            mx = 2*cx + cw;
            my = 2*cy + ch;
            nx = (mx < 2*bx) ? 2*bx : ((mx > 2*bx + 2*bw) ? 2*bx + 2*bw : mx);
            ny = (my < 2*by) ? 2*by : ((my > 2*by + 2*bh) ? 2*by + 2*bh : my);
            return ((nx - mx)*(nx - mx) + (ny - my)*(ny - my)) < cw*cw;
        endfunction

        function void accept_collider(collider_t c);
            longint   x, y, w, h, dx, dy;
            verdict_t v;
            x = longint'(c.pos_x) + longint'(c.shift_x);
            y = longint'(c.pos_y) + longint'(c.shift_y);
            w = scaled(c.box_w, c.scale_x);
            h = scaled(c.box_h, c.scale_y);
            if (c.op == OP_LOAD) begin
                ref_kind = c.kind;
                ref_x    = x;
                ref_y    = y;
                ref_w    = w;
                ref_h    = h;
                loads++;
                return;
            end
            if (ref_x + ref_w <= x || ref_x >= x + w || ref_y + ref_h <= y || ref_y >= y + h)
                v.hit = 1'b0;
            else if (ref_kind == KIND_BOX && c.kind == KIND_BOX)
                v.hit = 1'b1;
            else if (ref_kind == KIND_CIRCLE && c.kind == KIND_CIRCLE) begin
                dx = (2*x + w) - (2*ref_x + ref_w);
                dy = (2*y + h) - (2*ref_y + ref_h);
                v.hit = (dx*dx + dy*dy) < (ref_w + w)*(ref_w + w);
            end
            else if (ref_kind == KIND_BOX)
                v.hit = box_reaches_circle(ref_x, ref_y, ref_w, ref_h, x, y, w, h);
            else
                v.hit = box_reaches_circle(x, y, w, h, ref_x, ref_y, ref_w, ref_h);
            v.pair_kind = {ref_kind, c.kind};
            pending_verdicts.push_back(v);
            pairs_seen[v.pair_kind] = 1'b1;
            tests++;
            if (v.hit)
                hits++;
        endfunction

        function void check_verdict(logic hit, logic [1:0] pair_kind);
            verdict_t v;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result transaction: hit=%0d pair_kind=%0d", hit, pair_kind);
                errors++;
                return;
            end
            v = pending_verdicts.pop_front();
            if (hit !== v.hit) begin
                $error("hit: expected %0d, got %0d", v.hit, hit);
                errors++;
            end
            if (pair_kind !== v.pair_kind) begin
                $error("pair_kind: expected %0d, got %0d", v.pair_kind, pair_kind);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]         s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0] m_tdata;
    logic [1:0]         m_tuser;

    collision_predictor judge;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // Long receiver hold requests: the main flow bumps the ask count,
    // the receiver process bumps its own count when it starts one.
    int holds_asked   = 0;
    int holds_started = 0;
    int cycle_count   = 0;

    // Generator's view of the last loaded reference, used to aim tests at it.
    longint gen_ref_x = 0, gen_ref_y = 0, gen_ref_w = 0, gen_ref_h = 0;

    aabb_circle_collision_test_core #(
        .COORD_WIDTH    (COORD_W),
        .SIZE_WIDTH     (SIZE_W),
        .SCALE_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run if the cycle budget runs out.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, judge.pending_verdicts.size());
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random back-pressure, or a long hold when one is asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_started != holds_asked)
            begin
                holds_started++;
                for (int i = 0; i < LONG_HOLD; i++)
                begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Result monitor: values read here are the ones present before the edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            judge.check_verdict(m_tdata[0], m_tuser);
    end

    // Offer one collider, hold it until accepted, then tell the predictor.
    task automatic offer_collider(input collider_t c);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        // pos_x, pos_y, shift_x, shift_y, box_w, box_h, scale_x, scale_y from bit 0 up
        s_tdata  <= {c.scale_y, c.scale_x, c.box_h, c.box_w,
                     c.shift_y, c.shift_x, c.pos_y, c.pos_x};
        s_tuser  <= {c.kind, c.op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        judge.accept_collider(c);
        if (c.op == OP_LOAD)
        begin
            gen_ref_x = longint'(c.pos_x) + longint'(c.shift_x);
            gen_ref_y = longint'(c.pos_y) + longint'(c.shift_y);
            gen_ref_w = (longint'(c.box_w) * longint'(c.scale_x)) >>> FRAC_BITS;
            gen_ref_h = (longint'(c.box_h) * longint'(c.scale_y)) >>> FRAC_BITS;
        end
    endtask

    function automatic collider_t make_collider(op_t op, kind_t kind,
                                                longint px, longint py, longint sx, longint sy,
                                                longint bw, longint bh, longint kx, longint ky);
        collider_t c;
        c.op      = op;
        c.kind    = kind;
        c.pos_x   = COORD_W'(px);
        c.pos_y   = COORD_W'(py);
        c.shift_x = COORD_W'(sx);
        c.shift_y = COORD_W'(sy);
        c.box_w   = SIZE_W'(bw);
        c.box_h   = SIZE_W'(bh);
        c.scale_x = SCALE_WIDTH'(kx);
        c.scale_y = SCALE_WIDTH'(ky);
        return c;
    endfunction

    // Split a corner into a random position plus the offset that reaches it.
    function automatic void split_corner(longint t, output longint p, output longint s);
        logic signed [COORD_W-1:0] r;
        r = COORD_W'($urandom);
        p = longint'(r);
        s = t - p;
        if (s > COORD_MAX || s < COORD_MIN)
        begin
            p = t >>> 1;
            s = t - p;
        end
    endfunction

    function automatic longint random_corner();
        case ($urandom_range(0, 9))
            0:       return CORNER_MAX;
            1:       return CORNER_MIN;
            default: return longint'($urandom_range(0, 32'h1FF_FFFE)) + CORNER_MIN;
        endcase
    endfunction

    // Mostly moderate sizes, with full-range and extreme ones mixed in.
    function automatic void pick_size(output logic [SIZE_W-1:0] b,
                                      output logic [SCALE_WIDTH-1:0] k);
        case ($urandom_range(0, 9))
            0:
            begin
                b = $urandom_range(0, 1) ? '1 : '0;
                case ($urandom_range(0, 2))
                    0:       k = '0;
                    1:       k = '1;
                    default: k = 12'd256;
                endcase
            end
            1, 2:
            begin
                b = SIZE_W'($urandom);
                k = SCALE_WIDTH'($urandom);
            end
            default:
            begin
                b = SIZE_W'($urandom_range(0, 4095));
                k = SCALE_WIDTH'($urandom_range(64, 600));
            end
        endcase
    endfunction

    // Aim a corner so the box of size ts lands around the reference span.
    function automatic longint aim_corner(longint rc, longint rs, longint ts);
        longint t;
        case ($urandom_range(0, 9))
            0:       t = rc + rs;   // just touching on the far side
            1:       t = rc - ts;   // just touching on the near side
            2:       t = random_corner();
            default: t = rc - ts + longint'($urandom_range(0, int'(rs + ts)));
        endcase
        if (t > CORNER_MAX) t = CORNER_MAX;
        if (t < CORNER_MIN) t = CORNER_MIN;
        return t;
    endfunction

    function automatic collider_t placed_collider(op_t op, kind_t kind, bit aimed);
        collider_t              c;
        logic [SIZE_W-1:0]      bw, bh;
        logic [SCALE_WIDTH-1:0] kx, ky;
        longint                 tx, ty, px, py, sx, sy;
        pick_size(bw, kx);
        pick_size(bh, ky);
        if (aimed)
        begin
            tx = aim_corner(gen_ref_x, gen_ref_w, (longint'(bw) * longint'(kx)) >>> FRAC_BITS);
            ty = aim_corner(gen_ref_y, gen_ref_h, (longint'(bh) * longint'(ky)) >>> FRAC_BITS);
        end
        else
        begin
            tx = random_corner();
            ty = random_corner();
        end
        split_corner(tx, px, sx);
        split_corner(ty, py, sy);
        c = make_collider(op, kind, px, py, sx, sy, longint'(bw), longint'(bh),
                          longint'(kx), longint'(ky));
        return c;
    endfunction

    function automatic collider_t noise_collider();
        collider_t c;
        c = make_collider(op_t'($urandom_range(0, 1)), kind_t'($urandom_range(0, 1)),
                          0, 0, 0, 0, 0, 0, 0, 0);
        c.pos_x   = COORD_W'($urandom);
        c.pos_y   = COORD_W'($urandom);
        c.shift_x = COORD_W'($urandom);
        c.shift_y = COORD_W'($urandom);
        c.box_w   = SIZE_W'($urandom);
        c.box_h   = SIZE_W'($urandom);
        c.scale_x = SCALE_WIDTH'($urandom);
        c.scale_y = SCALE_WIDTH'($urandom);
        return c;
    endfunction

    // Random traffic: mostly a fresh reference followed by tests aimed at it;
    // sometimes the load is skipped, sometimes a fully random item slips in.
    task automatic run_phase(input int tx_pct, input int rx_pct, input int quota);
        int n;
        int sent;
        sent        = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (sent < quota)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                offer_collider(placed_collider(OP_LOAD, kind_t'($urandom_range(0, 1)), 1'b0));
                sent++;
            end
            n = $urandom_range(1, 8);
            repeat (n)
            begin
                offer_collider(placed_collider(OP_TEST, kind_t'($urandom_range(0, 1)), 1'b1));
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                offer_collider(noise_collider());
                sent++;
            end
        end
    endtask

    initial
    begin
        collider_t directed[$];

        judge = new();

        // Hold reset low, then release it for good.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tests before any load see a zero-size box at the origin.
        directed.push_back(make_collider(OP_TEST, KIND_BOX, -256, -256, 0, 0, 512, 512, 256, 256));
        directed.push_back(make_collider(OP_TEST, KIND_CIRCLE, -256, -256, 0, 0, 512, 512, 256, 256));
        directed.push_back(make_collider(OP_TEST, KIND_BOX, 0, 0, 0, 0, 0, 0, 256, 256));
        // Box reference: edge contact is not an overlap, one step inside is.
        directed.push_back(make_collider(OP_LOAD, KIND_BOX, 0, 0, 0, 0, 1024, 1024, 256, 256));
        directed.push_back(make_collider(OP_TEST, KIND_BOX, 1024, 0, 0, 0, 256, 256, 256, 256));
        directed.push_back(make_collider(OP_TEST, KIND_BOX, 1000, 0, 23, 0, 256, 256, 256, 256));
        // Circle against a box corner: inside, then outside the corner radius.
        directed.push_back(make_collider(OP_TEST, KIND_CIRCLE, 900, 900, 0, 0, 256, 256, 256, 256));
        directed.push_back(make_collider(OP_TEST, KIND_CIRCLE, 996, 996, 0, 0, 256, 256, 256, 256));
        // A circle of zero width never hits.
        directed.push_back(make_collider(OP_TEST, KIND_CIRCLE, 500, 500, 0, 0, 0, 256, 256, 256));
        // Circle reference: circle-circle and box-versus-circle-reference.
        directed.push_back(make_collider(OP_LOAD, KIND_CIRCLE, 0, 0, 0, 0, 1024, 1024, 256, 256));
        directed.push_back(make_collider(OP_TEST, KIND_CIRCLE, 700, 0, 0, 0, 1024, 1024, 256, 256));
        directed.push_back(make_collider(OP_TEST, KIND_CIRCLE, 1000, 1000, 0, 0, 1024, 1024, 256, 256));
        directed.push_back(make_collider(OP_TEST, KIND_BOX, 800, 800, 0, 0, 512, 512, 256, 256));
        directed.push_back(make_collider(OP_TEST, KIND_BOX, 900, 900, 0, 0, 512, 512, 256, 256));
        // Field extremes: largest corner and size, smallest corner, zero scale.
        directed.push_back(make_collider(OP_LOAD, KIND_BOX, COORD_MAX, COORD_MAX, COORD_MAX,
                                         COORD_MAX, 'hFFFF, 'hFFFF, 'hFFF, 'hFFF));
        directed.push_back(make_collider(OP_TEST, KIND_BOX, COORD_MAX, COORD_MAX, COORD_MAX,
                                         COORD_MAX, 'hFFFF, 'hFFFF, 'hFFF, 'hFFF));
        directed.push_back(make_collider(OP_TEST, KIND_CIRCLE, COORD_MAX, COORD_MAX, COORD_MAX,
                                         COORD_MAX, 'hFFFF, 'hFFFF, 'hFFF, 'hFFF));
        directed.push_back(make_collider(OP_LOAD, KIND_CIRCLE, COORD_MIN, COORD_MIN, COORD_MIN,
                                         COORD_MIN, 'hFFFF, 'hFFFF, 'hFFF, 'hFFF));
        directed.push_back(make_collider(OP_TEST, KIND_CIRCLE, COORD_MIN, COORD_MIN, COORD_MIN,
                                         COORD_MIN, 'hFFFF, 'hFFFF, 'hFFF, 'hFFF));
        directed.push_back(make_collider(OP_TEST, KIND_BOX, COORD_MAX, COORD_MAX, COORD_MAX,
                                         COORD_MAX, 'hFFFF, 'hFFFF, 'hFFF, 'hFFF));
        directed.push_back(make_collider(OP_LOAD, KIND_BOX, COORD_MIN, COORD_MAX, 0, 0,
                                         'hFFFF, 0, 0, 'hFFF));
        directed.push_back(make_collider(OP_TEST, KIND_BOX, COORD_MIN, COORD_MAX, 0, 0,
                                         'hFFFF, 'hFFFF, 'hFFF, 'hFFF));

        // Directed items go in back to back, with a steady receiver.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        foreach (directed[i])
            offer_collider(directed[i]);

        // Busy sender against a slow receiver, then the reverse.
        run_phase(25, 88, 270);
        run_phase(88, 25, 270);

        // Full rate both sides; a long receiver hold fills the pipe and
        // must push back on the input without losing anything.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        holds_asked++;
        run_phase(0, 0, 260);

        s_tvalid <= 1'b0;

        // Drain: wait for every owed verdict, then watch for strays.
        while (judge.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d loads and %0d tests (%0d hits, %0d misses)",
                 judge.loads, judge.tests, judge.hits, judge.tests - judge.hits);
        $display("Reference/test kind pairings exercised: %0d of 4, long receiver holds: %0d",
                 $countones(judge.pairs_seen), holds_started);

        if (judge.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
